### rtl/nms_pkg.sv
// Shared constants, types and helpers for the 3x3 non-maximum suppression stream.
// Depends on nothing; every other file refers to it by scoped names.
package nms_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int THR_BITS  = 16;
  localparam int SIZE_BITS = 11;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int KP_BITS   = 8;

  localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CNT_BITS = $clog2(MAX_DIM + 1);
  localparam int DIM_W    = (CNT_BITS > SIZE_BITS) ? CNT_BITS : SIZE_BITS;
  localparam int ADDR_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  localparam logic [KP_BITS-1:0] KP_PEAK = KP_BITS'(255);
  localparam logic [KP_BITS-1:0] KP_NONE = '0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [THR_BITS-1:0]    thr_t;
  typedef logic [SIZE_BITS-1:0]          size_t;
  typedef logic [DIM_W-1:0]              dim_t;
  typedef logic [ADDR_W-1:0]             addr_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  // One entry of the line store holds the two stored lines of one column.
  typedef struct packed {
    sample_t upper;
    sample_t lower;
  } lb_word_t;

  typedef struct packed {
    logic     rd_en;
    addr_t    rd_addr;
    logic     wr_en;
    addr_t    wr_addr;
    lb_word_t wr_data;
  } lb_req_t;

  // A zero size is taken as one and a size above the maximum saturates.
  function automatic dim_t clamp_dim(size_t v, dim_t maxv);
    dim_t ext;
    ext = DIM_W'(v);
    if (ext == '0) begin
      return DIM_W'(1);
    end
    return (ext > maxv) ? maxv : ext;
  endfunction

endpackage

### rtl/nms_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on nms_pkg for payload types.
interface nms_in_if;
  logic             valid;
  logic             ready;
  nms_pkg::sample_t response_sample;

  modport source (output valid, output response_sample, input ready);
  modport sink   (input valid, input response_sample, output ready);
endinterface

interface nms_out_if;
  logic                          valid;
  logic                          ready;
  logic [nms_pkg::KP_BITS-1:0]   keypoint;
  logic                          frame_done;

  modport source (output valid, output keypoint, output frame_done, input ready);
  modport sink   (input valid, input keypoint, input frame_done, output ready);
endinterface

interface nms_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nms_pkg::CFG_IDX_BITS-1:0]  index;
  logic [nms_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/nms_line_buf.sv
// Two-line store in one memory with a registered read port and a write port.
// Cleared by a sweep after reset; depends on nms_pkg.
module nms_line_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nms_pkg::lb_req_t  req_i,
  output nms_pkg::lb_word_t rd_data_o,
  output logic              clearing_o
);

  nms_pkg::lb_word_t mem [nms_pkg::MAX_WIDTH];
  nms_pkg::lb_word_t rd_q;
  logic              clr_q;
  nms_pkg::addr_t    clr_addr_q;

  logic              wr_en;
  nms_pkg::addr_t    wr_addr;
  nms_pkg::lb_word_t wr_data;

  always_comb begin
    if (clr_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = req_i.wr_en;
      wr_addr = req_i.wr_addr;
      wr_data = req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == nms_pkg::ADDR_W'(nms_pkg::MAX_WIDTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o  = rd_q;
  assign clearing_o = clr_q;

endmodule

### rtl/nms_peak_win.sv
// 3x3 window of samples and the strict local-maximum test on its next contents.
// Depends on nms_pkg.
module nms_peak_win (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  nms_pkg::sample_t col_i [3],
  input  nms_pkg::thr_t    thr_i,
  output logic             peak_o
);

  nms_pkg::sample_t win_q [3][3];
  nms_pkg::sample_t win_d [3][3];
  logic signed [nms_pkg::CMP_W-1:0] centre;
  logic [8:0] above;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
      win_d[i][2] = col_i[i];
    end
  end

  assign centre = nms_pkg::CMP_W'(win_d[1][1]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i == 1 && j == 1) begin
          above[3*i+j] = centre > nms_pkg::CMP_W'(thr_i);
        end else begin
          above[3*i+j] = centre > nms_pkg::CMP_W'(win_d[i][j]);
        end
      end
    end
  end

  assign peak_o = &above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

endmodule

### rtl/nms_3x3_local_max_stream.sv
// 3x3 non-maximum suppression over a raster stream; top level with counters and handshakes.
// Samples are registered in stage one, results in the output register. Throughput: one sample
// per cycle unless the output stalls, limited by the single line-store read and write port.
// After reset the line store is swept to zero over MAX_WIDTH (1024) entries; no samples are
// taken meanwhile, register writes are. Depends on nms_pkg, nms_if, nms_line_buf, nms_peak_win.
module nms_3x3_local_max_stream (
  input  logic clk_i,
  input  logic rst_ni,
  nms_cfg_if.sink   cfg_i,
  nms_in_if.sink    sample_i,
  nms_out_if.source result_o
);

  nms_pkg::thr_t  thr_q;
  nms_pkg::size_t width_q;
  nms_pkg::size_t height_q;
  nms_pkg::dim_t  row_q;
  nms_pkg::dim_t  col_q;

  nms_pkg::dim_t  w_eff;
  nms_pkg::dim_t  h_eff;
  nms_pkg::dim_t  r_cur;
  nms_pkg::dim_t  c_cur;
  logic           in_fire;
  logic           access;
  nms_pkg::sample_t sample_in;

  logic             s1_valid_q;
  logic             s1_access_q;
  logic             s1_emit_q;
  logic             s1_done_q;
  nms_pkg::addr_t   s1_addr_q;
  nms_pkg::sample_t s1_sample_q;
  logic             s1_go;

  logic                        out_valid_q;
  logic [nms_pkg::KP_BITS-1:0] keypoint_q;
  logic                        done_q;

  nms_pkg::lb_req_t  lb_req;
  nms_pkg::lb_word_t lb_rd;
  logic              clearing;
  nms_pkg::sample_t  col [3];
  logic              peak;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      width_q  <= nms_pkg::SIZE_BITS'(1024);
      height_q <= nms_pkg::SIZE_BITS'(1024);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        nms_pkg::REG_THRESHOLD:    thr_q    <= nms_pkg::thr_t'(cfg_i.data);
        nms_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_i.data[nms_pkg::SIZE_BITS-1:0];
        nms_pkg::REG_FRAME_HEIGHT: height_q <= cfg_i.data[nms_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff     = nms_pkg::clamp_dim(width_q, nms_pkg::DIM_W'(nms_pkg::MAX_WIDTH));
    h_eff     = nms_pkg::clamp_dim(height_q, nms_pkg::DIM_W'(nms_pkg::MAX_HEIGHT));
    r_cur     = (row_q > h_eff) ? h_eff : row_q;
    c_cur     = (col_q > w_eff) ? w_eff : col_q;
    access    = c_cur < w_eff;
    sample_in = (r_cur < h_eff && access) ? sample_i.response_sample : '0;
  end

  assign s1_go          = s1_valid_q && (!s1_emit_q || !out_valid_q || result_o.ready);
  assign sample_i.ready = !clearing && (!s1_valid_q || s1_go);
  assign in_fire        = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      if (c_cur >= w_eff) begin
        col_q <= '0;
        row_q <= (r_cur >= h_eff) ? '0 : r_cur + 1'b1;
      end else begin
        col_q <= c_cur + 1'b1;
        row_q <= r_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_access_q <= access;
      s1_emit_q   <= (r_cur != '0) && (c_cur != '0);
      s1_done_q   <= (r_cur == h_eff) && (c_cur == w_eff);
      s1_addr_q   <= c_cur[nms_pkg::ADDR_W-1:0];
      s1_sample_q <= sample_in;
    end
  end

  always_comb begin
    lb_req.rd_en         = in_fire && access;
    lb_req.rd_addr       = c_cur[nms_pkg::ADDR_W-1:0];
    lb_req.wr_en         = s1_go && s1_access_q;
    lb_req.wr_addr       = s1_addr_q;
    lb_req.wr_data.upper = lb_rd.lower;
    lb_req.wr_data.lower = s1_sample_q;
  end

  nms_line_buf u_line_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (lb_req),
    .rd_data_o  (lb_rd),
    .clearing_o (clearing)
  );

  always_comb begin
    col[0] = s1_access_q ? lb_rd.upper : '0;
    col[1] = s1_access_q ? lb_rd.lower : '0;
    col[2] = s1_sample_q;
  end

  nms_peak_win u_peak_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_go),
    .col_i   (col),
    .thr_i   (thr_q),
    .peak_o  (peak)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_emit_q) begin
      keypoint_q <= peak ? nms_pkg::KP_PEAK : nms_pkg::KP_NONE;
      done_q     <= s1_done_q;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.keypoint   = keypoint_q;
  assign result_o.frame_done = done_q;

  a_no_beat_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !sample_i.ready)
    else $error("sample taken during line store sweep");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_addr_q) && $stable(s1_sample_q))
    else $error("stalled stage lost its contents");

  a_frame_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit_q && s1_done_q |-> row_q == '0 && col_q == '0)
    else $error("frame end without counter wrap");

  a_counters_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= nms_pkg::DIM_W'(nms_pkg::MAX_WIDTH) && row_q <= nms_pkg::DIM_W'(nms_pkg::MAX_HEIGHT))
    else $error("position counter out of range");

endmodule

### bench/nms_3x3_local_max_stream_test.sv
// Self-checking bench for nms_3x3_local_max_stream: directed and random response frames,
// each accepted beat run through an in-bench copy of the window and checked against results.
// Depends on nms_pkg, the channel interfaces in nms_if and the top level of the block.
module nms_3x3_local_max_stream_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 36;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 4096;
  localparam int SMALL_ITEMS   = 1025;

  typedef struct {
    logic [nms_pkg::KP_BITS-1:0] keypoint;
    logic                        frame_done;
  } keypoint_beat_t;

  typedef enum int {MIX_FULL, MIX_TIES, MIX_EXTREME, MIX_PEAKY} sample_mix_e;

  class keypoint_board;
    nms_pkg::thr_t    threshold;
    nms_pkg::size_t   width_raw;
    nms_pkg::size_t   height_raw;
    nms_pkg::sample_t upper_line [nms_pkg::MAX_WIDTH];
    nms_pkg::sample_t lower_line [nms_pkg::MAX_WIDTH];
    nms_pkg::sample_t win [3][3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    keypoint_beat_t   due [$];
    int unsigned      failures;

    function new();
      threshold  = '0;
      width_raw  = nms_pkg::size_t'(nms_pkg::MAX_WIDTH);
      height_raw = nms_pkg::size_t'(nms_pkg::MAX_HEIGHT);
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      row_pos  = 0;
      col_pos  = 0;
      failures = 0;
    endfunction

    function int unsigned span(nms_pkg::size_t raw, int unsigned limit);
      if (raw == '0) return 1;
      return (int'(raw) > limit) ? limit : int'(raw);
    endfunction

    function void set_reg(nms_pkg::cfg_reg_e idx, logic [nms_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        nms_pkg::REG_THRESHOLD:    threshold  = nms_pkg::thr_t'(data);
        nms_pkg::REG_FRAME_WIDTH:  width_raw  = data[nms_pkg::SIZE_BITS-1:0];
        nms_pkg::REG_FRAME_HEIGHT: height_raw = data[nms_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit centre_wins();
      int centre;
      centre = win[1][1];
      if (centre <= int'(threshold)) return 1'b0;
      foreach (win[i, j]) begin
        if (!(i == 1 && j == 1) && centre <= int'(win[i][j])) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_sample(nms_pkg::sample_t raw);
      int unsigned      w;
      int unsigned      h;
      int unsigned      r;
      int unsigned      c;
      int               i;
      nms_pkg::sample_t fresh;
      nms_pkg::sample_t column [3];
      keypoint_beat_t   beat;
      w = span(width_raw, nms_pkg::MAX_WIDTH);
      h = span(height_raw, nms_pkg::MAX_HEIGHT);
      r = (row_pos > h) ? h : row_pos;
      c = (col_pos > w) ? w : col_pos;
      fresh = (r < h && c < w) ? raw : nms_pkg::sample_t'(0);
      column = '{default: '0};
      if (c < w) begin
        column[0] = upper_line[c];
        column[1] = lower_line[c];
        column[2] = fresh;
        upper_line[c] = column[1];
        lower_line[c] = fresh;
      end
      for (i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
        win[i][2] = column[i];
      end
      if (r >= 1 && c >= 1) begin
        beat.keypoint   = centre_wins() ? nms_pkg::KP_PEAK : nms_pkg::KP_NONE;
        beat.frame_done = (r == h && c == w);
        due.push_back(beat);
      end
      if (c >= w) begin
        col_pos = 0;
        row_pos = (r >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    task report(string msg);
      failures++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task check_keypoint(logic [nms_pkg::KP_BITS-1:0] kp, logic done);
      keypoint_beat_t want;
      if (due.size() == 0) begin
        report($sformatf("result beat (keypoint %0d) with nothing outstanding", kp));
        return;
      end
      want = due.pop_front();
      if (kp !== want.keypoint)
        report($sformatf("keypoint %0d, expected %0d", kp, want.keypoint));
      if (done !== want.frame_done)
        report($sformatf("frame_done %b, expected %b", done, want.frame_done));
    endtask
  endclass

  logic          clk_i      = 1'b0;
  logic          rst_ni     = 1'b0;
  logic          sink_ready = 1'b0;
  bit            calm       = 1'b0;
  int unsigned   quiet_cycles = 0;
  keypoint_board board      = new();

  nms_cfg_if cfg_ch ();
  nms_in_if  sample_ch ();
  nms_out_if result_ch ();

  assign result_ch.ready = sink_ready;

  nms_3x3_local_max_stream DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    sink_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_ch.valid && sink_ready)
        board.check_keypoint(result_ch.keypoint, result_ch.frame_done);
      if (sample_ch.valid && sample_ch.ready)
        board.take_sample(sample_ch.response_sample);
      if ((result_ch.valid && sink_ready) || (sample_ch.valid && sample_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("nms_3x3_local_max_stream_test NOT OK");
        $finish;
      end
    end
  end

  task automatic write_regs(logic [nms_pkg::CFG_DATA_BITS-1:0] thr,
                            logic [nms_pkg::CFG_DATA_BITS-1:0] wid,
                            logic [nms_pkg::CFG_DATA_BITS-1:0] hgt);
    nms_pkg::cfg_reg_e                 order [3];
    logic [nms_pkg::CFG_DATA_BITS-1:0] vals [3];
    order = '{nms_pkg::REG_THRESHOLD, nms_pkg::REG_FRAME_WIDTH, nms_pkg::REG_FRAME_HEIGHT};
    vals  = '{thr, wid, hgt};
    foreach (order[k]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= order[k];
      cfg_ch.data  <= vals[k];
      do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
      board.set_reg(order[k], vals[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_sample(nms_pkg::sample_t value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.response_sample <= value;
    do @(posedge clk_i); while (sample_ch.ready !== 1'b1);
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    do @(posedge clk_i); while (board.due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [nms_pkg::CFG_DATA_BITS-1:0] pick_size(int unsigned usual);
    logic [nms_pkg::CFG_DATA_BITS-1:0] raw;
    raw = nms_pkg::CFG_DATA_BITS'($urandom_range(usual, 1));
    case ($urandom_range(9))
      0: raw = '0;
      1: raw = nms_pkg::CFG_DATA_BITS'($urandom_range(2047, nms_pkg::MAX_WIDTH));
      default: ;
    endcase
    if ($urandom_range(3) == 0)
      raw[nms_pkg::CFG_DATA_BITS-1:nms_pkg::SIZE_BITS] = 5'($urandom_range(31));
    return raw;
  endfunction

  function automatic nms_pkg::sample_t draw_sample(sample_mix_e mix);
    case (mix)
      MIX_TIES: return nms_pkg::sample_t'($urandom_range(3));
      MIX_EXTREME: begin
        case ($urandom_range(5))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh7ffe;
          3: return 16'sh8001;
          4: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      MIX_PEAKY: begin
        if ($urandom_range(7) == 0) return nms_pkg::sample_t'($urandom_range(32767, 1));
        return nms_pkg::sample_t'(-int'($urandom_range(8, 1)));
      end
      default: return nms_pkg::sample_t'($urandom());
    endcase
  endfunction

  initial begin
    nms_pkg::sample_t                  script [$];
    sample_mix_e                       mix;
    int unsigned                       small_items;
    int unsigned                       phase;
    int unsigned                       w_eff;
    int unsigned                       h_eff;
    int unsigned                       frame_len;
    int unsigned                       count;
    logic [nms_pkg::CFG_DATA_BITS-1:0] thr_w;
    logic [nms_pkg::CFG_DATA_BITS-1:0] wid_w;
    logic [nms_pkg::CFG_DATA_BITS-1:0] hgt_w;

    cfg_ch.valid              <= 1'b0;
    cfg_ch.index              <= nms_pkg::REG_THRESHOLD;
    cfg_ch.data               <= '0;
    sample_ch.valid           <= 1'b0;
    sample_ch.response_sample <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-pixel frames: the lone pixel against zero padding, padding beats ignored.
    write_regs(16'h8000, 16'd0, 16'd0);
    script = '{16'sh7fff, 16'shffff, 16'sd12345, 16'sh8000,
               16'shffff, 16'sd5, 16'sd5, 16'sd5};
    foreach (script[i]) push_sample(script[i]);
    drain();

    // The threshold is exclusive.
    write_regs(16'd5, 16'd1, 16'd1);
    script = '{16'sd5, 16'sd100, 16'sd100, 16'sd100,
               16'sd6, 16'shffff, 16'shffff, 16'shffff};
    foreach (script[i]) push_sample(script[i]);
    drain();

    // Two by two with equal neighbours and both sample extremes; upper data bits set.
    write_regs(16'h8000, 16'hf802, 16'd2);
    script = '{16'sd100, 16'sd100, 16'sd7, 16'sh8000, 16'sh7fff, -16'sd7,
               16'sd1, 16'sd2, 16'sd3};
    foreach (script[i]) push_sample(script[i]);
    drain();

    small_items = 0;
    phase       = 0;
    while (small_items < SMALL_ITEMS) begin
      case ($urandom_range(4))
        0: thr_w = 16'h8000;
        1: thr_w = 16'h7fff;
        2: thr_w = nms_pkg::CFG_DATA_BITS'($urandom_range(4)) - 16'd2;
        default: thr_w = nms_pkg::CFG_DATA_BITS'($urandom());
      endcase
      wid_w = pick_size(10);
      hgt_w = pick_size(6);
      w_eff = board.span(wid_w[nms_pkg::SIZE_BITS-1:0], nms_pkg::MAX_WIDTH);
      h_eff = board.span(hgt_w[nms_pkg::SIZE_BITS-1:0], nms_pkg::MAX_HEIGHT);
      frame_len = (w_eff + 1) * (h_eff + 1);
      if (w_eff > 16 || h_eff > 16) begin
        count = $urandom_range(200, 20);
      end else begin
        count = $urandom_range(3 * frame_len, 1);
      end
      mix  = sample_mix_e'($urandom_range(3));
      calm = (phase >= 6 && phase < 12);
      write_regs(thr_w, wid_w, hgt_w);
      repeat (count) push_sample(draw_sample(mix));
      drain();
      small_items += count;
      phase++;
    end

    if (board.failures == 0) begin
      $display("nms_3x3_local_max_stream_test OK");
    end else begin
      $display("nms_3x3_local_max_stream_test NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/nms_pkg.sv
rtl/nms_if.sv
rtl/nms_line_buf.sv
rtl/nms_peak_win.sv
rtl/nms_3x3_local_max_stream.sv
bench/nms_3x3_local_max_stream_test.sv
